[hdl/gbw_pkg.sv]
// Shared types, codes and latency constants for the grid bilinear warp.
package gbw_pkg;

  // opcode values
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LINE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_SAMP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_LINE_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SAMP_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS     = 3'd5;

  // reset values; 1.0 in Q8.24
  localparam logic [31:0] INV_STEP_ONE = 32'h0100_0000;
  localparam logic [6:0]  GRID_DIM_RST = 7'd2;

  // signed Q.24 cell fraction and wide blend operand
  localparam int FRAC_W = 53;
  localparam int WIDE_W = 65;
  typedef logic signed [FRAC_W-1:0] frac_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // pipeline depths
  localparam int LOC_LAT    = 4;
  localparam int MUL_LAT    = 6;
  localparam int VALID_LAT  = LOC_LAT + 4 + 2 * MUL_LAT + 2;
  localparam int RESULT_LAT = VALID_LAT + 2;

endpackage

[hdl/gbw_delay.sv]
// Fixed-length register delay line for pipeline payload.
module gbw_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  // shift one place per cycle
  always_ff @(posedge clk) begin
    sr[0] <= d;
    for (int i = 1; i < N; i++) begin
      sr[i] <= sr[i-1];
    end
  end

  assign q = sr[N-1];

endmodule

[hdl/gbw_locate.sv]
// Per-axis grid locator: offset, reciprocal scale, cell clamp and fraction.
module gbw_locate #(
  parameter int N_MAX = 64
) (
  input  logic                         clk,
  input  logic signed [31:0]           q,
  input  logic signed [31:0]           org,
  input  logic [31:0]                  inv,
  input  logic [$clog2(N_MAX+1)-1:0]   n,
  output logic [$clog2(N_MAX)-1:0]     cell_idx,
  output gbw_pkg::frac_t               frac
);
  import gbw_pkg::*;

  localparam int CW = $clog2(N_MAX);
  localparam int NW = $clog2(N_MAX + 1);

  logic signed [32:0] d;
  logic [32:0]        negd;
  logic [31:0]        mag;
  logic               neg1;
  logic               neg2;
  logic [63:0]        p;
  logic [NW-1:0]      lim;
  logic [27:0]        c_hi;
  logic [FRAC_W-1:0]  pq;
  logic [CW-1:0]      cell_next;
  frac_t              frac_next;

  // offset from the grid origin, exact
  always_ff @(posedge clk) begin
    d <= {q[31], q} - {org[31], org};
  end

  // magnitude of the offset always fits 32 bits
  assign negd = -d;
  always_ff @(posedge clk) begin
    neg1 <= d[32];
    mag  <= d[32] ? negd[31:0] : d[31:0];
  end

  // scale by reciprocal step, Q.36 product
  always_ff @(posedge clk) begin
    p    <= mag * inv;
    neg2 <= neg1;
  end

  // truncate toward zero, clamp to last full cell, form fraction
  assign lim  = n - NW'(2);
  assign c_hi = p[63:36];
  assign pq   = {1'b0, p[63:12]};
  always_comb begin
    if (neg2) begin
      cell_next = '0;
      frac_next = -frac_t'(pq);
    end else if (c_hi > 28'(lim)) begin
      cell_next = CW'(lim);
      frac_next = frac_t'(pq - (FRAC_W'(lim) << 24));
    end else begin
      cell_next = CW'(c_hi);
      frac_next = frac_t'({29'b0, p[35:12]});
    end
  end

  always_ff @(posedge clk) begin
    cell_idx <= cell_next;
    frac     <= frac_next;
  end

endmodule

[hdl/gbw_scale_mul.sv]
// Pipelined f*x/2^24 with round half away from zero, magnitude held at 2^62.
module gbw_scale_mul (
  input  logic               clk,
  input  gbw_pkg::frac_t     f,
  input  gbw_pkg::wide_t     x,
  output logic signed [63:0] r
);
  import gbw_pkg::*;

  localparam int PW = 117;

  logic [FRAC_W-1:0] negf;
  logic [WIDE_W-1:0] negx;
  logic [51:0]       a;
  logic [63:0]       b;
  logic              neg_a, neg_b, neg_c, neg_d, neg_e;
  logic [63:0]       p00, p01, p11;
  logic [51:0]       p10;
  logic [63:0]       p00_c, p11_c;
  logic [64:0]       mid;
  logic [PW-1:0]     sum;
  logic [92:0]       qt;
  logic [62:0]       mag;

  // operand magnitudes and product sign
  assign negf = -f;
  assign negx = -x;
  always_ff @(posedge clk) begin
    neg_a <= f[FRAC_W-1] ^ x[WIDE_W-1];
    a     <= f[FRAC_W-1] ? negf[51:0] : f[51:0];
    b     <= x[WIDE_W-1] ? negx[63:0] : x[63:0];
  end

  // partial products, 32x32 at most
  always_ff @(posedge clk) begin
    p00   <= a[31:0] * b[31:0];
    p01   <= a[31:0] * b[63:32];
    p10   <= a[51:32] * b[31:0];
    p11   <= a[51:32] * b[63:32];
    neg_b <= neg_a;
  end

  // middle column
  always_ff @(posedge clk) begin
    mid   <= {1'b0, p01} + {13'b0, p10};
    p00_c <= p00;
    p11_c <= p11;
    neg_c <= neg_b;
  end

  // full product plus rounding bias
  always_ff @(posedge clk) begin
    sum   <= {53'b0, p00_c} + ({52'b0, mid} << 32) + ({53'b0, p11_c} << 64)
             + PW'(1 << 23);
    neg_d <= neg_c;
  end

  // drop fraction bits and hold at 2^62
  assign qt = sum[PW-1:24];
  always_ff @(posedge clk) begin
    mag   <= (qt > 93'(64'h4000_0000_0000_0000)) ? 63'h4000_0000_0000_0000 : qt[62:0];
    neg_e <= neg_d;
  end

  // reapply sign
  always_ff @(posedge clk) begin
    r <= neg_e ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

[hdl/grid_bilinear_coordinate_warp.sv]
// Grid bilinear coordinate warp: node tables, locate and blend pipeline.
//
// One item is taken per clock with no gaps. A query result appears on
// mapped_line, mapped_samp and saturated, marked by done; loads give no
// result. The pipeline never stalls, so busy is high only while rst is
// asserted and results must be captured in the cycle done is high. The
// delay from query to result comes from the locate path (offset, 32x32
// reciprocal multiply, clamp), the node table read, and two chained blend
// multipliers of six stages each. Node
// tables are two copies of a one-write, two-read memory so all four cell
// corners are read in one cycle; node writes take place in the same stage as
// reads, so loads and queries keep their order. Tables are not cleared at
// reset. Configuration registers must be written only while no query is in
// flight.
module grid_bilinear_coordinate_warp #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            opcode,
  input  logic [11:0]                     node_index,
  input  logic signed [31:0]              node_line,
  input  logic signed [31:0]              node_samp,
  input  logic signed [31:0]              query_line,
  input  logic signed [31:0]              query_samp,
  output logic                            done,
  output logic signed [31:0]              mapped_line,
  output logic signed [31:0]              mapped_samp,
  output logic                            saturated,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gbw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import gbw_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RCW   = $clog2(MAX_ROWS);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS);
  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int LD_W  = AW + 64;

  // configuration registers
  logic signed [31:0] origin_line, origin_samp;
  logic [31:0]        inv_line_step, inv_samp_step;
  logic [6:0]         grid_rows, grid_cols;
  logic [31:0]        rows_wide, cols_wide;
  logic [RNW-1:0]     rows_eff;
  logic [CNW-1:0]     cols_eff;

  // control pipeline
  logic                 acc;
  logic                 s1_v, s1_lv;
  logic [VALID_LAT-1:0] vpipe;
  logic [LOC_LAT:0]     lpipe;

  // stage 1 payload
  logic signed [31:0] s1_ql, s1_qs;
  logic [LD_W-1:0]    s1_ld, s6_ld;

  // locate outputs and table addresses
  logic [RCW-1:0] cell_l;
  logic [CCW-1:0] cell_s;
  frac_t          frac_l, frac_s, fl8, fs8, fs16;
  logic [AW-1:0]  k00, k01, k10, k11;

  // node tables, {line, samp}
  logic [63:0] mem_a [DEPTH];
  logic [63:0] mem_b [DEPTH];
  logic [63:0] ra0, ra1, rb0, rb1;

  // blend datapath
  wide_t              dl0, dl1, ds0, ds1;
  logic [127:0]       u8, u14;
  logic signed [63:0] rl0, rl1, rs0, rs1;
  logic signed [63:0] x1l, x2l, x1s, x2s;
  logic signed [63:0] x1l_d, x1s_d, x1l_22, x1s_22;
  wide_t              ddl, dds;
  logic signed [63:0] sl, ss;
  logic signed [64:0] vl, vs;
  logic               hi_l, lo_l, hi_s, lo_s;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign acc       = start && !busy;

  // register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_line   <= '0;
      origin_samp   <= '0;
      inv_line_step <= INV_STEP_ONE;
      inv_samp_step <= INV_STEP_ONE;
      grid_rows     <= GRID_DIM_RST;
      grid_cols     <= GRID_DIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_LINE:   origin_line   <= cfg_data;
        REG_ORIGIN_SAMP:   origin_samp   <= cfg_data;
        REG_INV_LINE_STEP: inv_line_step <= cfg_data;
        REG_INV_SAMP_STEP: inv_samp_step <= cfg_data;
        REG_GRID_ROWS:     grid_rows     <= cfg_data[6:0];
        REG_GRID_COLS:     grid_cols     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // grid size held to [2, max]
  always_comb begin
    rows_wide = 32'(grid_rows);
    cols_wide = 32'(grid_cols);
    if (rows_wide < 32'd2) rows_wide = 32'd2;
    else if (rows_wide > 32'(MAX_ROWS)) rows_wide = 32'(MAX_ROWS);
    if (cols_wide < 32'd2) cols_wide = 32'd2;
    else if (cols_wide > 32'(MAX_COLS)) cols_wide = 32'(MAX_COLS);
  end
  assign rows_eff = RNW'(rows_wide);
  assign cols_eff = CNW'(cols_wide);

  // accept stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s1_lv <= 1'b0;
    end else begin
      s1_v  <= acc && (opcode == OP_QUERY);
      s1_lv <= acc && (opcode == OP_LOAD) && (32'(node_index) < 32'(DEPTH));
    end
  end
  always_ff @(posedge clk) begin
    s1_ql <= query_line;
    s1_qs <= query_samp;
    s1_ld <= {AW'(node_index), node_line, node_samp};
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
      lpipe <= '0;
    end else begin
      vpipe <= {vpipe[VALID_LAT-2:0], s1_v};
      lpipe <= {lpipe[LOC_LAT-1:0], s1_lv};
    end
  end

  gbw_delay #(.W(LD_W), .N(LOC_LAT + 1)) u_ld_dly (
    .clk (clk), .d (s1_ld), .q (s6_ld)
  );

  // per-axis locate
  gbw_locate #(.N_MAX(MAX_ROWS)) u_loc_line (
    .clk (clk), .q (s1_ql), .org (origin_line), .inv (inv_line_step),
    .n (rows_eff), .cell_idx (cell_l), .frac (frac_l)
  );
  gbw_locate #(.N_MAX(MAX_COLS)) u_loc_samp (
    .clk (clk), .q (s1_qs), .org (origin_samp), .inv (inv_samp_step),
    .n (cols_eff), .cell_idx (cell_s), .frac (frac_s)
  );

  // corner address
  always_ff @(posedge clk) begin
    k00 <= AW'(cell_l) * AW'(cols_eff) + AW'(cell_s);
  end
  assign k01 = k00 + AW'(1);
  assign k10 = k00 + AW'(cols_eff);
  assign k11 = k10 + AW'(1);

  // table write for loads, corner reads for queries, same stage
  always_ff @(posedge clk) begin
    if (lpipe[LOC_LAT]) begin
      mem_a[s6_ld[LD_W-1:64]] <= s6_ld[63:0];
      mem_b[s6_ld[LD_W-1:64]] <= s6_ld[63:0];
    end
    ra0 <= mem_a[k00];
    ra1 <= mem_a[k01];
    rb0 <= mem_b[k10];
    rb1 <= mem_b[k11];
  end

  // corner differences along the line axis
  always_ff @(posedge clk) begin
    dl0 <= WIDE_W'($signed(rb0[63:32])) - WIDE_W'($signed(ra0[63:32]));
    dl1 <= WIDE_W'($signed(rb1[63:32])) - WIDE_W'($signed(ra1[63:32]));
    ds0 <= WIDE_W'($signed(rb0[31:0])) - WIDE_W'($signed(ra0[31:0]));
    ds1 <= WIDE_W'($signed(rb1[31:0])) - WIDE_W'($signed(ra1[31:0]));
    u8  <= {ra0[63:32], ra1[63:32], ra0[31:0], ra1[31:0]};
  end

  gbw_delay #(.W(FRAC_W), .N(3)) u_fl_dly (.clk (clk), .d (frac_l), .q (fl8));
  gbw_delay #(.W(FRAC_W), .N(3)) u_fs_dly (.clk (clk), .d (frac_s), .q (fs8));
  gbw_delay #(.W(FRAC_W), .N(MUL_LAT + 2)) u_fs_dly2 (.clk (clk), .d (fs8), .q (fs16));
  gbw_delay #(.W(128), .N(MUL_LAT)) u_u_dly (.clk (clk), .d (u8), .q (u14));

  // line-axis blends
  gbw_scale_mul u_ml0 (.clk (clk), .f (fl8), .x (dl0), .r (rl0));
  gbw_scale_mul u_ml1 (.clk (clk), .f (fl8), .x (dl1), .r (rl1));
  gbw_scale_mul u_ms0 (.clk (clk), .f (fl8), .x (ds0), .r (rs0));
  gbw_scale_mul u_ms1 (.clk (clk), .f (fl8), .x (ds1), .r (rs1));

  always_ff @(posedge clk) begin
    x1l <= 64'($signed(u14[127:96])) + rl0;
    x2l <= 64'($signed(u14[95:64]))  + rl1;
    x1s <= 64'($signed(u14[63:32]))  + rs0;
    x2s <= 64'($signed(u14[31:0]))   + rs1;
  end

  // sample-axis difference
  always_ff @(posedge clk) begin
    ddl   <= WIDE_W'(x2l) - WIDE_W'(x1l);
    dds   <= WIDE_W'(x2s) - WIDE_W'(x1s);
    x1l_d <= x1l;
    x1s_d <= x1s;
  end

  gbw_delay #(.W(128), .N(MUL_LAT)) u_x1_dly (
    .clk (clk), .d ({x1l_d, x1s_d}), .q ({x1l_22, x1s_22})
  );

  gbw_scale_mul u_m2l (.clk (clk), .f (fs16), .x (ddl), .r (sl));
  gbw_scale_mul u_m2s (.clk (clk), .f (fs16), .x (dds), .r (ss));

  // final sum
  always_ff @(posedge clk) begin
    vl <= 65'(x1l_22) + 65'(sl);
    vs <= 65'(x1s_22) + 65'(ss);
  end

  // saturate to 32 bits
  assign hi_l = !vl[64] && (vl[63:31] != '0);
  assign lo_l =  vl[64] && (vl[63:31] != '1);
  assign hi_s = !vs[64] && (vs[63:31] != '0);
  assign lo_s =  vs[64] && (vs[63:31] != '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vpipe[VALID_LAT-1];
    end
  end
  always_ff @(posedge clk) begin
    mapped_line <= hi_l ? 32'sh7FFF_FFFF : (lo_l ? 32'sh8000_0000 : vl[31:0]);
    mapped_samp <= hi_s ? 32'sh7FFF_FFFF : (lo_s ? 32'sh8000_0000 : vs[31:0]);
    saturated   <= hi_l | lo_l | hi_s | lo_s;
  end

endmodule

[hdl/gbw_checker.sv]
// Port-level checks for the grid bilinear warp, bound to the top level.
module gbw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          opcode,
  input logic                          done,
  input logic signed [31:0]            mapped_line,
  input logic signed [31:0]            mapped_samp,
  input logic                          saturated
);
  import gbw_pkg::*;

  // every result comes from a query transfer a fixed time earlier
  a_done_from_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && opcode == OP_QUERY, RESULT_LAT))
    else $error("result without matching query");

  // every query transfer yields a result
  a_query_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_QUERY) |-> ##RESULT_LAT done)
    else $error("query result lost");

  // a clipped result sits at a range limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (mapped_line == 32'sh7FFF_FFFF || mapped_line == 32'sh8000_0000 ||
       mapped_samp == 32'sh7FFF_FFFF || mapped_samp == 32'sh8000_0000))
    else $error("saturated flag without clipped output");

endmodule

bind grid_bilinear_coordinate_warp gbw_checker u_gbw_checker (.*);
